// ===== rtl/point_proximity_mask_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for point_proximity_mask
// Shared property forms for the checks in the proximity mask RTL.
// ---------------------------------------------------------------------------
`ifndef POINT_PROXIMITY_MASK_ASSERT_SVH
`define POINT_PROXIMITY_MASK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("point_proximity_mask: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("point_proximity_mask: next-cycle check failed");

`endif

// ===== rtl/ppm_pkg.sv =====
// ---------------------------------------------------------------------------
// ppm_pkg
// Types, widths and codes shared by the proximity mask modules.
// ---------------------------------------------------------------------------
package ppm_pkg;

  // Default capacity of the reference store.
  localparam int DEF_REF_DEPTH = 1024;

  // Field widths.
  localparam int COORD_W = 32;
  localparam int OP_W    = 2;
  localparam int THR_W   = 63;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int SUM_W   = SQ_W + 2;

  // Operation codes carried on the input tuser.
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // One 3D point; x sits in the lowest bits.
  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  // Status from the distance pipeline back to the controller.
  typedef struct packed {
    logic busy;
    logic hit_valid;
    logic hit;
  } dist_status_t;

endpackage

// ===== rtl/ppm_ref_store.sv =====
// ---------------------------------------------------------------------------
// ppm_ref_store
// Reference point memory with one write port, one read port and a registered read.
// ---------------------------------------------------------------------------
module ppm_ref_store
  import ppm_pkg::*;
#(
  parameter int REF_DEPTH = DEF_REF_DEPTH,
  parameter int AW        = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  point_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output point_t        rd_data
);

  point_t mem [REF_DEPTH];

  // Writes and reads never target the same cycle, so no bypass is needed.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/ppm_dist_pipe.sv =====
// ---------------------------------------------------------------------------
// ppm_dist_pipe
// Pipelined exact squared distance and threshold compare, one entry a cycle.
// ---------------------------------------------------------------------------
module ppm_dist_pipe
  import ppm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_issue,
  input  point_t           ref_pt,
  input  point_t           qry_pt,
  input  logic [THR_W-1:0] radius_sq,
  output dist_status_t     status
);

  logic                v_data;
  logic                v_mag;
  logic                v_sq;
  logic                v_sum;
  logic [COORD_W-1:0]  mag_x;
  logic [COORD_W-1:0]  mag_y;
  logic [COORD_W-1:0]  mag_z;
  logic [SQ_W-1:0]     sq_x;
  logic [SQ_W-1:0]     sq_y;
  logic [SQ_W-1:0]     sq_z;
  logic [SUM_W-1:0]    sum;

  // Magnitude of a difference of two signed coordinates; it always fits 32 bits.
  function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                  input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic        [COORD_W:0] m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? (~d + 1'b1) : d;
    return m[COORD_W-1:0];
  endfunction

  // Valid bits follow each entry through the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_data <= 1'b0;
      v_mag  <= 1'b0;
      v_sq   <= 1'b0;
      v_sum  <= 1'b0;
    end else begin
      v_data <= rd_issue;
      v_mag  <= v_data;
      v_sq   <= v_mag;
      v_sum  <= v_sq;
    end
  end

  // Stage one: absolute differences; stage two: squares; stage three: sum.
  always_ff @(posedge clk) begin
    mag_x <= abs_diff(qry_pt.x, ref_pt.x);
    mag_y <= abs_diff(qry_pt.y, ref_pt.y);
    mag_z <= abs_diff(qry_pt.z, ref_pt.z);
    sq_x  <= mag_x * mag_x;
    sq_y  <= mag_y * mag_y;
    sq_z  <= mag_z * mag_z;
    sum   <= SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
  end

  // A distance equal to the threshold counts as near.
  always_comb begin
    status.busy      = v_data | v_mag | v_sq | v_sum;
    status.hit_valid = v_sum;
    status.hit       = v_sum && (sum <= SUM_W'(radius_sq));
  end

endmodule

// ===== rtl/point_proximity_mask.sv =====
// ---------------------------------------------------------------------------
// point_proximity_mask
// Fixed-radius near-neighbour test of query points against a stored set.
// ---------------------------------------------------------------------------
// Clear and load beats never hold the input off. A query walks the N stored
// references through the single read port of the reference memory, one entry
// a cycle into the distance pipeline, and lets the pipeline drain; the next
// beat is taken once its result is in the output register. A query of an
// empty set skips the scan and goes straight to its result.
// While an earlier result still waits for m_tready, a finished query holds
// the input off until the output register frees. The store needs no clearing
// pass after reset: only entries below the fill count are read.
module point_proximity_mask
  import ppm_pkg::*;
#(
  parameter int REF_DEPTH = DEF_REF_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [THR_W-1:0] cfg_wdata,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [95:0]      s_tdata,   // coord_x, coord_y, coord_z
  input  logic [OP_W-1:0]  s_tuser,   // operation
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata    // far_flag, simulate_flag, overflow_seen, zeros
);

`include "point_proximity_mask_assert.svh"

  localparam int AW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int CW = $clog2(REF_DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]       state;
  logic [CW-1:0]    ref_count;
  logic [CW-1:0]    scan_addr;
  logic             overflow_sticky;
  logic             any_near;
  logic [THR_W-1:0] radius_sq;
  point_t           qry_pt;
  point_t           in_pt;
  point_t           rd_data;
  dist_status_t     dstat;
  logic             accept;
  logic             rd_en;
  logic             wr_en;
  logic             out_free;
  logic             far;

  assign in_pt    = s_tdata;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign rd_en    = (state == ST_SCAN);
  assign wr_en    = accept && (s_tuser == OP_LOAD) && (ref_count < CW'(REF_DEPTH));
  assign out_free = !m_tvalid || m_tready;
  assign far      = (ref_count != '0) && !any_near;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_sq <= '0;
    end else if (cfg_wen) begin
      radius_sq <= cfg_wdata;
    end
  end

  // Reference store.
  ppm_ref_store #(
    .REF_DEPTH (REF_DEPTH),
    .AW        (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ref_count[AW-1:0]),
    .wr_data (in_pt),
    .rd_en   (rd_en),
    .rd_addr (scan_addr[AW-1:0]),
    .rd_data (rd_data)
  );

  // Distance pipeline.
  ppm_dist_pipe u_dist (
    .clk       (clk),
    .rst       (rst),
    .rd_issue  (rd_en),
    .ref_pt    (rd_data),
    .qry_pt    (qry_pt),
    .radius_sq (radius_sq),
    .status    (dstat)
  );

  // Query coordinates are held for the length of the scan.
  always_ff @(posedge clk) begin
    if (accept && (s_tuser == OP_QUERY)) begin
      qry_pt <= in_pt;
    end
  end

  // Sequencer: store updates, scan of the set and result hand-off.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      ref_count       <= '0;
      scan_addr       <= '0;
      overflow_sticky <= 1'b0;
      any_near        <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (s_tuser)
              OP_CLEAR: begin
                ref_count <= '0;
              end
              OP_LOAD: begin
                if (ref_count < CW'(REF_DEPTH)) begin
                  ref_count <= ref_count + CW'(1);
                end else begin
                  overflow_sticky <= 1'b1;
                end
              end
              OP_QUERY: begin
                any_near  <= 1'b0;
                scan_addr <= '0;
                state     <= (ref_count == '0) ? ST_FIN : ST_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          scan_addr <= scan_addr + CW'(1);
          if (scan_addr + CW'(1) == ref_count) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!dstat.busy) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // Fold each compare result into the near flag.
      if (dstat.hit_valid && dstat.hit) begin
        any_near <= 1'b1;
      end
    end
  end

  // Output register; a finished result waits here while loads carry on.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_FIN) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && out_free) begin
      m_tdata <= {5'b0, overflow_sticky, ~far, far};
    end
  end

  // Checks on the sequencer and the store.
  `PPM_ASSERT_NOW(a_idle_pipe_empty, state == ST_IDLE, !dstat.busy)
  `PPM_ASSERT_NOW(a_read_in_range, rd_en, scan_addr < ref_count)
  `PPM_ASSERT_NOW(a_count_bound, 1'b1, ref_count <= CW'(REF_DEPTH))
  `PPM_ASSERT_NEXT(a_overflow_sticky, overflow_sticky, overflow_sticky)

endmodule
